@@ hw/rtl/urt_pkg.sv @@
// Shared types, constants and a helper function of the radix-to-text converter.
`default_nettype none

package urt_pkg;

  localparam int NUMBER_BITS_DEF = 32;
  localparam int STEP_BITS       = 8;

  localparam int RADIX_W  = 8;
  localparam int CAP_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int DIGIT_W  = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN      = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 8'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 8'h41;

  localparam logic [STATUS_W-1:0] ST_OK             = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID_ACCESS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE_CHECK    = 2'd2;

  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                emit_init;
    logic                rd_en;
    logic                load_char;
    logic                load_err;
    logic [STATUS_W-1:0] err_code;
    logic                idx_dec;
  } urt_cmd_t;

  typedef struct packed {
    logic bad_access;
    logic bad_radix;
    logic last_chunk;
    logic quot_zero;
    logic too_long;
    logic out_last;
  } urt_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] v);
    logic [CHAR_W-1:0] res;
    if (v >= DECIMAL_DIGITS) begin
      res = ASCII_UPPER_A + CHAR_W'(v - DECIMAL_DIGITS);
    end else begin
      res = ASCII_ZERO + CHAR_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/urt_if.sv @@
// Valid/ready channel interfaces for the request and the character stream.
`default_nettype none

interface urt_in_if #(
  parameter int NUMBER_BITS = urt_pkg::NUMBER_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [NUMBER_BITS-1:0]       number;
  logic [urt_pkg::RADIX_W-1:0]  radix;
  logic [urt_pkg::CAP_W-1:0]    capacity;
  logic                         writable;

  modport source (output valid, number, radix, capacity, writable, input ready);
  modport sink   (input valid, number, radix, capacity, writable, output ready);
endinterface

interface urt_out_if;
  logic                          valid;
  logic                          ready;
  logic [urt_pkg::STATUS_W-1:0]  status;
  logic [urt_pkg::CHAR_W-1:0]    digit_char;
  logic [urt_pkg::COUNT_W-1:0]   digit_count;
  logic                          last;

  modport source (output valid, status, digit_char, digit_count, last, input ready);
  modport sink   (input valid, status, digit_char, digit_count, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/urt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module urt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/urt_ctrl.sv @@
// Controller state machine that sequences checks, division steps and character output.
`default_nettype none

module urt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire urt_pkg::urt_stat_t st,
  output urt_pkg::urt_cmd_t       cmd
);

  import urt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK_IN,
    S_DIV,
    S_CHECK_LEN,
    S_READ,
    S_LOAD,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK_IN;
        end
      end
      S_CHECK_IN: begin
        if (st.bad_access) begin
          cmd.load_err = 1'b1;
          cmd.err_code = ST_INVALID_ACCESS;
          state_nxt    = S_HOLD;
        end else if (st.bad_radix) begin
          cmd.load_err = 1'b1;
          cmd.err_code = ST_RANGE_CHECK;
          state_nxt    = S_HOLD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.last_chunk && st.quot_zero) begin
          state_nxt = S_CHECK_LEN;
        end
      end
      S_CHECK_LEN: begin
        if (st.too_long) begin
          cmd.load_err = 1'b1;
          cmd.err_code = ST_RANGE_CHECK;
          state_nxt    = S_HOLD;
        end else begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_char = 1'b1;
        state_nxt     = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          if (st.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= (state_nxt == S_HOLD);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("Input accepted while a result is pending.");

  a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_HOLD))
    else $error("Result shown outside the hold state.");

  a_ready_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("Input ready outside the idle state.");

endmodule

`default_nettype wire

@@ hw/rtl/urt_dp.sv @@
// Datapath: request registers, radix divider, digit store and output registers.
`default_nettype none

module urt_dp #(
  parameter int NUMBER_BITS = urt_pkg::NUMBER_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire urt_pkg::urt_cmd_t             cmd,
  output urt_pkg::urt_stat_t                 st,
  input  wire logic [NUMBER_BITS-1:0]        in_number,
  input  wire logic [urt_pkg::RADIX_W-1:0]   in_radix,
  input  wire logic [urt_pkg::CAP_W-1:0]     in_capacity,
  input  wire logic                          in_writable,
  output logic      [urt_pkg::STATUS_W-1:0]  out_status,
  output logic      [urt_pkg::CHAR_W-1:0]    out_digit_char,
  output logic      [urt_pkg::COUNT_W-1:0]   out_digit_count,
  output logic                               out_last
);

  import urt_pkg::*;

  localparam int CHUNKS   = (NUMBER_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = CHUNKS * STEP_BITS;
  localparam int CH_W     = $clog2(CHUNKS + 1);
  localparam int AW       = $clog2(NUMBER_BITS);
  localparam int CNT_W    = $clog2(NUMBER_BITS + 1);

  logic [PAD_BITS-1:0] work_r;
  logic [DIGIT_W-1:0]  rem_r;
  logic [CH_W-1:0]     chunk_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [AW-1:0]       idx_r;
  logic [RADIX_W-1:0]  radix_r;
  logic [CAP_W-1:0]    cap_r;
  logic                writable_r;

  logic [STATUS_W-1:0] status_r;
  logic [CHAR_W-1:0]   char_r;
  logic [COUNT_W-1:0]  count_r;
  logic                last_r;

  logic [STEP_BITS-1:0] top_bits;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   rem_nxt;
  logic [PAD_BITS-1:0]  work_nxt;
  logic [DIGIT_W:0]     trial;
  logic [RADIX_W-1:0]   trial_ext;
  logic                 last_chunk;
  logic                 digit_wr;
  logic [DIGIT_W-1:0]   rd_digit;

  // Restoring division, several quotient bits per cycle, MSB first.
  always_comb begin
    top_bits  = work_r[PAD_BITS-1 -: STEP_BITS];
    rem_nxt   = rem_r;
    qbits     = '0;
    trial     = '0;
    trial_ext = '0;
    for (int j = STEP_BITS - 1; j >= 0; j--) begin
      trial     = {rem_nxt, top_bits[j]};
      trial_ext = RADIX_W'(trial);
      if (trial_ext >= radix_r) begin
        qbits[j] = 1'b1;
        rem_nxt  = DIGIT_W'(trial_ext - radix_r);
      end else begin
        rem_nxt  = trial[DIGIT_W-1:0];
      end
    end
    work_nxt = (work_r << STEP_BITS) | PAD_BITS'(qbits);
  end

  assign last_chunk = (chunk_r == CH_W'(CHUNKS - 1));
  assign digit_wr   = cmd.div_step && last_chunk;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r     <= PAD_BITS'(in_number);
      radix_r    <= in_radix;
      cap_r      <= in_capacity;
      writable_r <= in_writable;
      rem_r      <= '0;
      chunk_r    <= '0;
      cnt_r      <= '0;
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      if (last_chunk) begin
        rem_r   <= '0;
        chunk_r <= '0;
        cnt_r   <= cnt_r + 1'b1;
      end else begin
        rem_r   <= rem_nxt;
        chunk_r <= chunk_r + 1'b1;
      end
    end
    if (cmd.emit_init) begin
      idx_r <= AW'(cnt_r - 1'b1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.load_err) begin
      status_r <= cmd.err_code;
      char_r   <= '0;
      count_r  <= '0;
      last_r   <= 1'b1;
    end else if (cmd.load_char) begin
      status_r <= ST_OK;
      char_r   <= digit_to_ascii(rd_digit);
      count_r  <= COUNT_W'(cnt_r);
      last_r   <= (idx_r == '0);
    end
  end

  urt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (NUMBER_BITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (digit_wr),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (rem_nxt),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_digit)
  );

  always_comb begin
    st            = '0;
    st.bad_access = !writable_r;
    st.bad_radix  = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    st.last_chunk = last_chunk;
    st.quot_zero  = (work_nxt == '0);
    st.too_long   = (CAP_W'(cnt_r) > cap_r);
    st.out_last   = last_r;
  end

  assign out_status      = status_r;
  assign out_digit_char  = char_r;
  assign out_digit_count = count_r;
  assign out_last        = last_r;

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_wr |-> (cnt_r < CNT_W'(NUMBER_BITS)))
    else $error("Digit store written beyond its depth.");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (RADIX_W'(rem_r) < radix_r))
    else $error("Partial remainder not below the radix.");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_init |-> (cnt_r != '0))
    else $error("Character output started with no digits.");

endmodule

`default_nettype wire

@@ hw/rtl/unsigned_radix_to_text_core.sv @@
// Top level of the unsigned integer to text converter for radix 2 to 36.
//
// Usage: one request transaction on in_ch carries number, radix, capacity and
// writable. The block answers on out_ch with one transaction per character,
// most significant digit first, as ASCII '0'-'9' and 'A'-'Z', each carrying
// the total digit count and a last flag on the final character. A request
// without write permission, with a radix outside 2 to 36, or with more digits
// than capacity gives a single error transaction with no character.
// The divider retires one digit per pass over the number, 8 quotient bits per
// cycle, most significant chunk first; the digit count is then checked against
// capacity, and each character is read back from the digit store before it is
// offered. A permission or radix error is found before any division step.
// One request is processed at a time; in_ch.ready is high only when idle.
// When the receiver stalls, the pending result transaction holds its payload
// until accepted. Reset returns the controller to idle; no clearing pass.
`default_nettype none

module unsigned_radix_to_text_core #(
  parameter int NUMBER_BITS = urt_pkg::NUMBER_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  urt_in_if.sink     in_ch,
  urt_out_if.source  out_ch
);

  import urt_pkg::*;

  urt_cmd_t  cmd;
  urt_stat_t st;

  urt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  urt_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_number       (in_ch.number),
    .in_radix        (in_ch.radix),
    .in_capacity     (in_ch.capacity),
    .in_writable     (in_ch.writable),
    .out_status      (out_ch.status),
    .out_digit_char  (out_ch.digit_char),
    .out_digit_count (out_ch.digit_count),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire
